/* sv/dqu_pkg.sv */
// ----------------------------------------------------------------------------
// dqu_pkg
// Shared types and codes for the double-ended queue unit: operation and
// status codes, and the control word broadcast along the cell chains.
// ----------------------------------------------------------------------------
`default_nettype none

package dqu_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OCC_W  = 5;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned STAT_W = 2;

    // operation codes carried by an input transaction
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } t_op;

    // status codes carried by a result transaction
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // what every cell of one chain does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_IN   = 2'd1,
        CELL_SHIFT_OUT  = 2'd2,
        CELL_WRITE_TAIL = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [WORD_W-1:0]  data;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* sv/dqu_if.sv */
// ----------------------------------------------------------------------------
// dqu_req_if / dqu_rsp_if
// Valid/ready channels of the double-ended queue unit: the operation
// request and the result that every request produces.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqu_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface dqu_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] popped_value;
    logic signed [31:0] front_word;
    logic signed [31:0] back_word;
    logic               is_empty;
    logic [4:0]         occupancy;
    logic [1:0]         status;

    modport source (output valid, output popped_value, output front_word,
                    output back_word, output is_empty, output occupancy,
                    output status, input ready);
    modport sink   (input valid, input popped_value, input front_word,
                    input back_word, input is_empty, input occupancy,
                    input status, output ready);
endinterface

`default_nettype wire

/* sv/double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of 32-bit words built from two chains of cells.
// ----------------------------------------------------------------------------
// The unit holds up to CAPACITY signed 32-bit words and takes one operation
// per transaction: push back, push front, pop back or pop front. Each
// operation yields one result with the popped word, the front and back words
// after the operation, an empty flag, the occupancy (low five bits) and a
// status; a pop on an empty queue reports underflow and a push on a full
// queue reports overflow, and both leave the queue unchanged. The contents
// are kept twice, in a front chain with the front word in its first cell and
// a back chain with the back word in its first cell, so a push shifts one
// chain one place and writes the tail of the other, and a pop shifts one
// chain alone. The result is registered and shows in the cycle after the
// request is accepted; one transaction is accepted per cycle, paced by the
// result register: a request is taken whenever it is empty or its result
// is taken in the same cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit
    import dqu_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dqu_req_if.sink    i_req,
    dqu_rsp_if.source  o_rsp
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_popped;
    logic [WORD_W-1:0] r_front;
    logic [WORD_W-1:0] r_back;
    logic              r_empty;
    logic [OCC_W-1:0]  r_occ;
    t_status           r_status;

    t_op               w_op;
    logic              w_accept;
    logic              w_full;
    logic              w_none;
    t_cell_ctrl        w_front_ctrl;
    t_cell_ctrl        w_back_ctrl;
    logic [IDX_W-1:0]  w_tail_idx;
    logic [WORD_W-1:0] w_front_head;
    logic [WORD_W-1:0] w_front_head_next;
    logic [WORD_W-1:0] w_back_head;
    logic [WORD_W-1:0] w_back_head_next;
    logic [WORD_W-1:0] w_popped;
    t_status           w_status;

    // request handshake
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_op        = t_op'(i_req.operation);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_none      = (r_count == '0);
    assign w_tail_idx  = r_count[IDX_W-1:0];

    // chain control and count update per operation
    always_comb begin
        w_front_ctrl.op   = CELL_HOLD;
        w_front_ctrl.data = i_req.push_value;
        w_back_ctrl.op    = CELL_HOLD;
        w_back_ctrl.data  = i_req.push_value;
        n_count           = r_count;
        w_popped          = '0;
        w_status          = ST_OK;
        if (w_accept) begin
            case (w_op)
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        w_status = ST_OVERFLOW;
                    end else begin
                        w_front_ctrl.op = CELL_WRITE_TAIL;
                        w_back_ctrl.op  = CELL_SHIFT_IN;
                        n_count         = r_count + 1'b1;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        w_status = ST_OVERFLOW;
                    end else begin
                        w_front_ctrl.op = CELL_SHIFT_IN;
                        w_back_ctrl.op  = CELL_WRITE_TAIL;
                        n_count         = r_count + 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (w_none) begin
                        w_status = ST_UNDERFLOW;
                    end else begin
                        w_back_ctrl.op = CELL_SHIFT_OUT;
                        w_popped       = w_back_head;
                        n_count        = r_count - 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (w_none) begin
                        w_status = ST_UNDERFLOW;
                    end else begin
                        w_front_ctrl.op = CELL_SHIFT_OUT;
                        w_popped        = w_front_head;
                        n_count         = r_count - 1'b1;
                    end
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
        end
    end

    // front chain: front word in cell 0
    dqu_chain #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_front_chain (
        .i_clk       (i_clk),
        .i_ctrl      (w_front_ctrl),
        .i_tail_idx  (w_tail_idx),
        .o_head      (w_front_head),
        .o_head_next (w_front_head_next)
    );

    // back chain: back word in cell 0
    dqu_chain #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_back_chain (
        .i_clk       (i_clk),
        .i_ctrl      (w_back_ctrl),
        .i_tail_idx  (w_tail_idx),
        .o_head      (w_back_head),
        .o_head_next (w_back_head_next)
    );

    // occupancy register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, captured on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= w_popped;
            r_front  <= (n_count != '0) ? w_front_head_next : '0;
            r_back   <= (n_count != '0) ? w_back_head_next : '0;
            r_empty  <= (n_count == '0);
            r_occ    <= OCC_W'(n_count);
            r_status <= w_status;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.popped_value = r_popped;
    assign o_rsp.front_word   = r_front;
    assign o_rsp.back_word    = r_back;
    assign o_rsp.is_empty     = r_empty;
    assign o_rsp.occupancy    = r_occ;
    assign o_rsp.status       = r_status;

`ifndef SYNTHESIS
    // occupancy never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    // a push on a full queue reports overflow and keeps the count
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (w_op == OP_PUSH_BACK || w_op == OP_PUSH_FRONT))
        |=> (r_out_valid && r_status == ST_OVERFLOW && $stable(r_count)))
        else $error("full push not reported as overflow");

    // a pop on an empty queue reports underflow and pops nothing
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_none && (w_op == OP_POP_BACK || w_op == OP_POP_FRONT))
        |=> (r_out_valid && r_status == ST_UNDERFLOW && r_popped == '0 && r_empty))
        else $error("empty pop not reported as underflow");

    // an empty result shows zero end words
    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_empty) |-> (r_front == '0 && r_back == '0))
        else $error("empty result with nonzero end word");
`endif

endmodule

`default_nettype wire

/* sv/dqu_cell.sv */
// ----------------------------------------------------------------------------
// dqu_cell
// One storage cell of a chain. It takes the word of its head-side neighbor
// on a shift in, the word of its tail-side neighbor on a shift out, or the
// broadcast word when the tail index names its own position.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_cell
    import dqu_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int unsigned IDX_W = 4
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic [IDX_W-1:0]  i_tail_idx,
    input  wire logic [WORD_W-1:0] i_prev_word,
    input  wire logic [WORD_W-1:0] i_next_word,
    output logic      [WORD_W-1:0] o_word,
    output logic      [WORD_W-1:0] o_word_next
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    // next word by the chain-wide operation
    always_comb begin
        case (i_ctrl.op)
            CELL_SHIFT_IN:   n_word = i_prev_word;
            CELL_SHIFT_OUT:  n_word = i_next_word;
            CELL_WRITE_TAIL: n_word = (i_tail_idx == IDX_W'(INDEX)) ? i_ctrl.data : r_word;
            default:         n_word = r_word;
        endcase
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word      = r_word;
    assign o_word_next = n_word;

endmodule

`default_nettype wire

/* sv/dqu_chain.sv */
// ----------------------------------------------------------------------------
// dqu_chain
// A row of cells holding the queue with one end fixed at cell 0. Shifts
// move every word one place at once; a tail write lands at the cell named
// by the occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_chain
    import dqu_pkg::*;
#(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned IDX_W    = 4
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic [IDX_W-1:0]  i_tail_idx,
    output logic      [WORD_W-1:0] o_head,
    output logic      [WORD_W-1:0] o_head_next
);

    logic [WORD_W-1:0] w_word      [CAPACITY];
    logic [WORD_W-1:0] w_word_next [CAPACITY];

    // row of cells, each wired to its two neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] w_prev;
        logic [WORD_W-1:0] w_next;

        if (g == 0) begin : g_head
            assign w_prev = i_ctrl.data;
        end else begin : g_body
            assign w_prev = w_word[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next = w_word[g];
        end else begin : g_inner
            assign w_next = w_word[g+1];
        end

        dqu_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (i_ctrl),
            .i_tail_idx  (i_tail_idx),
            .i_prev_word (w_prev),
            .i_next_word (w_next),
            .o_word      (w_word[g]),
            .o_word_next (w_word_next[g])
        );
    end

    assign o_head      = w_word[0];
    assign o_head_next = w_word_next[0];

endmodule

`default_nettype wire

/* test/dqu_result_checker.sv */
// ----------------------------------------------------------------------------
// dqu_result_checker
// Watches both channels of the double-ended queue unit, keeps its own ring
// buffer copy of the queue, works out the result of every accepted request
// and compares each accepted result with the oldest outstanding one.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_result_checker
    import dqu_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dqu_req_if        i_req,
    dqu_rsp_if        i_rsp,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // one result transaction as the queue should report it
    typedef struct packed {
        logic signed [WORD_W-1:0] popped;
        logic signed [WORD_W-1:0] front;
        logic signed [WORD_W-1:0] back;
        logic                     empty;
        logic [OCC_W-1:0]         occ;
        t_status                  status;
    } t_outcome;

    logic [WORD_W-1:0] ring [CAPACITY];
    int unsigned       head_pos;
    int unsigned       word_cnt;
    t_outcome          outstanding_outcomes [$];
    t_outcome          want;
    t_outcome          got;
    int                fail_total;

    function automatic int unsigned ring_slot(input int unsigned offset);
        return (head_pos + offset) % CAPACITY;
    endfunction

    // apply one operation to the local copy and return what the unit reports
    function automatic t_outcome apply_deque_op(input t_op op, input logic [WORD_W-1:0] word);
        t_outcome r;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (word_cnt >= CAPACITY) begin
                    r.status = ST_OVERFLOW;
                end else if (op == OP_PUSH_BACK) begin
                    ring[ring_slot(word_cnt)] = word;
                    word_cnt++;
                end else begin
                    head_pos = ring_slot(CAPACITY - 1);
                    ring[head_pos] = word;
                    word_cnt++;
                end
            end
            default: begin
                if (word_cnt == 0) begin
                    r.status = ST_UNDERFLOW;
                end else if (op == OP_POP_BACK) begin
                    r.popped = ring[ring_slot(word_cnt - 1)];
                    word_cnt--;
                end else begin
                    r.popped = ring[head_pos];
                    head_pos = ring_slot(1);
                    word_cnt--;
                end
            end
        endcase
        // front and back read zero on an empty queue
        if (word_cnt != 0) begin
            r.front = ring[head_pos];
            r.back  = ring[ring_slot(word_cnt - 1)];
        end
        r.empty = (word_cnt == 0);
        r.occ   = OCC_W'(word_cnt);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint want_v,
                                   input longint got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want_v, got_v);
        fail_total++;
    endtask

    // field-by-field comparison against the oldest outstanding result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_pos = 0;
            word_cnt = 0;
            outstanding_outcomes.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.popped = i_rsp.popped_value;
                got.front  = i_rsp.front_word;
                got.back   = i_rsp.back_word;
                got.empty  = i_rsp.is_empty;
                got.occ    = i_rsp.occupancy;
                got.status = t_status'(i_rsp.status);
                if (outstanding_outcomes.size() == 0) begin
                    $display({"%0t: result transaction with none outstanding, ",
                              "expected none, actual popped %0d status %0d"},
                             $realtime, got.popped, got.status);
                    fail_total++;
                end else begin
                    want = outstanding_outcomes[0];
                    outstanding_outcomes.delete(0);
                    if (got.popped !== want.popped)
                        report_mismatch("popped_value", want.popped, got.popped);
                    if (got.front !== want.front)
                        report_mismatch("front_word", want.front, got.front);
                    if (got.back !== want.back)
                        report_mismatch("back_word", want.back, got.back);
                    if (got.empty !== want.empty)
                        report_mismatch("is_empty", want.empty, got.empty);
                    if (got.occ !== want.occ)
                        report_mismatch("occupancy", want.occ, got.occ);
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                end
            end
            // a result always comes from an earlier request, so predict last
            if (i_req.valid && i_req.ready) begin
                outstanding_outcomes.insert(outstanding_outcomes.size(),
                    apply_deque_op(t_op'(i_req.operation), i_req.push_value));
            end
        end
        o_pending    <= outstanding_outcomes.size();
        o_fail_count <= fail_total;
    end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the double-ended queue unit: directed corner
// operations, then random operation mixes that sweep the fill level between
// empty and full under three idle profiles on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import dqu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY     = 16;
    localparam int          PHASE_ITEMS  = 450;
    localparam int          SETTLE_TICKS = 8;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   fail_count;
    int   pending_count;

    dqu_req_if req_ch ();
    dqu_rsp_if rsp_ch ();

    double_ended_queue_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    dqu_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("** double_ended_queue_unit: FAILED **");
        $finish;
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // one request transaction, with random idle cycles ahead of it
    task automatic send_op(input t_op op, input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid      <= 1'b0;
            req_ch.operation  <= 2'($urandom);
            req_ch.push_value <= $urandom;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.push_value <= word;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // hold requests off until every outstanding result has been taken
    task automatic drain_queue();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // random mixes: push-heavy runs fill the queue, pop-heavy runs empty it
    task automatic random_phase(input int n_items);
        int sent;
        int run_len;
        int push_pct;
        int drain_at;
        t_op op;
        sent     = 0;
        drain_at = $urandom_range(n_items / 4, 3 * n_items / 4);
        while (sent < n_items) begin
            run_len = $urandom_range(8, 40);
            case ($urandom_range(2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            repeat (run_len) begin
                if ($urandom_range(99) < push_pct)
                    op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else
                    op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                send_op(op, pick_word());
                sent++;
                if (sent == drain_at)
                    drain_queue();
            end
        end
    endtask

    // stimulus
    initial begin
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_PUSH_BACK;
        req_ch.push_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   = 22;
        sink_stall_pct = 58;

        // underflow on both ends of an empty queue
        send_op(OP_POP_BACK, 32'h1234_5678);
        send_op(OP_POP_FRONT, 32'hFFFF_FFFF);
        // fill from both ends with extreme words, wrapping the front pointer
        send_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h0000_0000);
        for (int k = 4; k < CAPACITY; k++)
            send_op(k[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
        // overflow on both ends of a full queue
        send_op(OP_PUSH_BACK, 32'h5555_5555);
        send_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);

        random_phase(PHASE_ITEMS);
        drain_queue();

        src_idle_pct   = 58;
        sink_stall_pct = 22;
        random_phase(PHASE_ITEMS);
        drain_queue();

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        random_phase(PHASE_ITEMS);
        drain_queue();

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** double_ended_queue_unit: PASSED **");
        end else begin
            $display("** double_ended_queue_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
